[design/ljpfa_pkg.sv]
`timescale 1ns / 1ps
package ljpfa_pkg;

  localparam int COORD_FRAC_BITS_DEF = 16;
  localparam int ACC_WIDTH_DEF       = 48;
  localparam int WORK_FRAC           = 32;
  localparam int OUT_FRAC            = 24;
  localparam int FIELD_W             = 48;
  localparam int ID_W                = 16;
  localparam int POS_W               = 32;
  localparam int STEP_W              = 2;
  localparam int COUNT_W             = 17;
  localparam int LEN_W               = 31;
  localparam int COEF_W              = 32;
  localparam int DIST_W              = 35;
  localparam int CFG_IDX_W           = 3;
  localparam int CFG_DATA_W          = 32;
  localparam int SH_W                = 6;
  localparam int OP_W                = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_PARTICLE_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PARTICLE_LIMIT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_LEN       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF_SQUARED = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF_RADIUS  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ENERGY_SHIFT   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_ENERGY_SLOPE   = 3'd6;

  localparam logic [COUNT_W-1:0] RST_PARTICLE_COUNT = 17'd1;
  localparam logic [COUNT_W-1:0] RST_PARTICLE_LIMIT = 17'd65536;
  localparam logic [LEN_W-1:0]   RST_CELL_LEN       = 31'd163840;
  localparam logic [LEN_W-1:0]   RST_CUTOFF_SQUARED = 31'd409600;
  localparam logic [LEN_W-1:0]   RST_CUTOFF_RADIUS  = 31'd163840;

  localparam logic [OP_W-1:0] OP_SQX  = 4'd0;
  localparam logic [OP_W-1:0] OP_SQY  = 4'd1;
  localparam logic [OP_W-1:0] OP_M1   = 4'd2;
  localparam logic [OP_W-1:0] OP_INV6 = 4'd3;
  localparam logic [OP_W-1:0] OP_M3   = 4'd4;
  localparam logic [OP_W-1:0] OP_F0   = 4'd5;
  localparam logic [OP_W-1:0] OP_F    = 4'd6;
  localparam logic [OP_W-1:0] OP_AX   = 4'd7;
  localparam logic [OP_W-1:0] OP_AY   = 4'd8;
  localparam logic [OP_W-1:0] OP_PE0  = 4'd9;
  localparam logic [OP_W-1:0] OP_PE   = 4'd10;
  localparam logic [OP_W-1:0] OP_SL   = 4'd11;

  localparam logic signed [63:0] W_HALF  = 64'sh0000_0000_8000_0000;
  localparam logic signed [63:0] W_ONE   = 64'sh0000_0001_0000_0000;
  localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

  typedef struct packed {
    logic            load;
    logic            calc_dist;
    logic            calc_r2;
    logic            mul_start;
    logic [OP_W-1:0] op;
    logic            div_start;
    logic            div_mean;
    logic            sqrt_start;
    logic            emit;
  } dp_cmd_t;

  typedef struct packed {
    logic skip;
    logic r2_skip;
    logic mul_done;
    logic div_busy;
    logic sqrt_busy;
    logic last_n;
    logic last_s;
  } dp_stat_t;

  function automatic logic [63:0] mag(input logic signed [63:0] a);
    return a[63] ? 64'd0 - a : a;
  endfunction

  function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) return a[63] ? S64_MIN : S64_MAX;
    return s;
  endfunction

  function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                 input logic signed [63:0] b);
    logic signed [63:0] s;
    s = a - b;
    if (a[63] != b[63] && s[63] != a[63]) return a[63] ? S64_MIN : S64_MAX;
    return s;
  endfunction

  function automatic logic signed [63:0] clamp(input logic signed [63:0] v, input int w);
    logic signed [63:0] hi;
    logic signed [63:0] top;
    hi  = v >>> (w - 1);
    top = (64'sd1 <<< (w - 1)) - 64'sd1;
    if (hi == 64'sd0 || hi == -64'sd1) return v;
    return v[63] ? -top - 64'sd1 : top;
  endfunction

endpackage

[design/ljpfa_mul.sv]
`timescale 1ns / 1ps
module ljpfa_mul (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic signed [63:0]           a,
  input  logic signed [63:0]           b,
  input  logic [ljpfa_pkg::SH_W-1:0]   sh,
  output logic                         done,
  output logic signed [63:0]           result
);
  import ljpfa_pkg::*;

  logic               busy;
  logic [2:0]         phase;
  logic [63:0]        ua;
  logic [63:0]        ub;
  logic               neg;
  logic [SH_W-1:0]    shift;
  logic [63:0]        pp;
  logic [1:0]         pp_off;
  logic [127:0]       acc;
  logic [127:0]       shv;
  logic [31:0]        ha;
  logic [31:0]        hb;
  logic [63:0]        prod;
  logic signed [63:0] sat_val;

  assign ha   = phase[1] ? ua[63:32] : ua[31:0];
  assign hb   = phase[0] ? ub[63:32] : ub[31:0];
  assign prod = ha * hb;

  always_comb begin
    if (neg) begin
      if (shv[127:64] != 64'd0 || shv[63:0] > 64'h8000_0000_0000_0000) sat_val = S64_MIN;
      else sat_val = 64'd0 - shv[63:0];
    end else begin
      if (shv[127:64] != 64'd0 || shv[63]) sat_val = S64_MAX;
      else sat_val = shv[63:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      phase <= 3'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        phase <= 3'd0;
      end else if (busy) begin
        phase <= phase + 3'd1;
        if (phase == 3'd6) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      ua     <= mag(a);
      ub     <= mag(b);
      neg    <= a[63] ^ b[63];
      shift  <= sh;
      acc    <= '0;
      pp     <= '0;
      pp_off <= 2'd0;
    end else if (busy) begin
      if (phase <= 3'd3) begin
        pp     <= prod;
        pp_off <= {1'b0, phase[1]} + {1'b0, phase[0]};
      end
      if (phase >= 3'd1 && phase <= 3'd4) acc <= acc + ({64'd0, pp} << {pp_off, 5'd0});
      if (phase == 3'd5) shv <= acc >> shift;
      if (phase == 3'd6) result <= sat_val;
    end
  end

endmodule

[design/ljpfa_div.sv]
`timescale 1ns / 1ps
module ljpfa_div #(
  parameter int W = 65
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] num,
  input  logic [63:0]  den,
  output logic         busy,
  output logic [W-1:0] quo
);
  localparam int CNT_W = $clog2(W + 1);

  logic [W-1:0]     nsh;
  logic [63:0]      den_r;
  logic [63:0]      rem;
  logic [CNT_W-1:0] cnt;
  logic [64:0]      trial;
  logic [64:0]      diff;
  logic             fit;

  assign trial = {rem, nsh[W-1]};
  assign fit   = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(W);
    end else if (busy) begin
      cnt <= cnt - CNT_W'(1);
      if (cnt == CNT_W'(1)) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      nsh   <= num;
      den_r <= den;
      rem   <= '0;
      quo   <= '0;
    end else if (busy) begin
      nsh <= nsh << 1;
      rem <= fit ? diff[63:0] : trial[63:0];
      quo <= {quo[W-2:0], fit};
    end
  end

endmodule

[design/ljpfa_sqrt.sv]
`timescale 1ns / 1ps
module ljpfa_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] val,
  output logic        busy,
  output logic [31:0] root
);
  logic [63:0] v;
  logic [63:0] res;
  logic [63:0] bitv;
  logic [4:0]  cnt;
  logic [63:0] tsum;
  logic        ge;

  assign tsum = res + bitv;
  assign ge   = v >= tsum;
  assign root = res[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= 5'd0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 5'd0;
    end else if (busy) begin
      cnt <= cnt + 5'd1;
      if (cnt == 5'd31) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      v    <= val;
      res  <= '0;
      bitv <= 64'h4000_0000_0000_0000;
    end else if (busy) begin
      if (ge) begin
        v   <= v - tsum;
        res <= (res >> 1) + bitv;
      end else begin
        res <= res >> 1;
      end
      bitv <= bitv >> 2;
    end
  end

endmodule

[design/ljpfa_datapath.sv]
`timescale 1ns / 1ps
module ljpfa_datapath #(
  parameter int COORD_FRAC_BITS = ljpfa_pkg::COORD_FRAC_BITS_DEF,
  parameter int ACC_WIDTH       = ljpfa_pkg::ACC_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [ljpfa_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ljpfa_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic [ljpfa_pkg::ID_W-1:0]            own_id,
  input  logic [ljpfa_pkg::ID_W-1:0]            neighbour_id,
  input  logic signed [ljpfa_pkg::POS_W-1:0]    own_x,
  input  logic signed [ljpfa_pkg::POS_W-1:0]    own_y,
  input  logic signed [ljpfa_pkg::POS_W-1:0]    neighbour_x,
  input  logic signed [ljpfa_pkg::POS_W-1:0]    neighbour_y,
  input  logic signed [ljpfa_pkg::STEP_W-1:0]   cell_step_x,
  input  logic signed [ljpfa_pkg::STEP_W-1:0]   cell_step_y,
  input  logic                                  last_neighbour,
  input  logic                                  last_of_step,
  input  ljpfa_pkg::dp_cmd_t                    cmd,
  output ljpfa_pkg::dp_stat_t                   stat,
  output logic signed [ljpfa_pkg::FIELD_W-1:0]  accel_x,
  output logic signed [ljpfa_pkg::FIELD_W-1:0]  accel_y,
  output logic signed [ljpfa_pkg::FIELD_W-1:0]  mean_energy,
  output logic                                  step_done
);
  import ljpfa_pkg::*;

  localparam int F      = COORD_FRAC_BITS;
  localparam int DIV_W  = (WORK_FRAC + 2 * F + 1 > 64) ? WORK_FRAC + 2 * F + 1 : 64;
  localparam int ACC_SH = WORK_FRAC + F - OUT_FRAC;
  localparam int UP_SH  = WORK_FRAC - F;

  logic [COUNT_W-1:0]       particle_count;
  logic [COUNT_W-1:0]       particle_limit;
  logic [LEN_W-1:0]         cell_len;
  logic [LEN_W-1:0]         cutoff_squared;
  logic [LEN_W-1:0]         cutoff_radius;
  logic signed [COEF_W-1:0] energy_shift;
  logic signed [COEF_W-1:0] energy_slope;

  logic [ID_W-1:0]           oid;
  logic [ID_W-1:0]           nid;
  logic signed [POS_W-1:0]   ox;
  logic signed [POS_W-1:0]   oy;
  logic signed [POS_W-1:0]   nx;
  logic signed [POS_W-1:0]   ny;
  logic signed [STEP_W-1:0]  sx;
  logic signed [STEP_W-1:0]  sy;
  logic                      last_n;
  logic                      last_s;

  logic signed [DIST_W-1:0]  dist_x;
  logic signed [DIST_W-1:0]  dist_y;
  logic [DIST_W-1:0]         ux;
  logic [DIST_W-1:0]         uy;
  logic                      used;
  logic                      far;

  logic signed [63:0]        sqx;
  logic signed [63:0]        sqy;
  logic [63:0]               r2;
  logic signed [63:0]        t1;
  logic signed [63:0]        inv6;
  logic signed [63:0]        frc;
  logic signed [63:0]        pe;
  logic signed [ACC_WIDTH-1:0] sum_ax;
  logic signed [ACC_WIDTH-1:0] sum_ay;
  logic signed [63:0]        sum_e;

  logic signed [63:0]        op_a;
  logic signed [63:0]        op_b;
  logic [SH_W-1:0]           op_sh;
  logic                      mul_done;
  logic signed [63:0]        mul_res;

  logic [DIV_W-1:0]          div_num;
  logic [63:0]               div_den;
  logic                      div_busy;
  logic [DIV_W-1:0]          quo;
  logic                      sqrt_busy;
  logic [31:0]               root;

  logic signed [63:0]        inv2;
  logic signed [33:0]        diff;
  logic signed [63:0]        diff_up;
  logic signed [63:0]        eshift_up;
  logic [63:0]               cut_lim;
  logic signed [63:0]        mean64;
  logic [COUNT_W-1:0]        count1;

  function automatic logic signed [DIST_W-1:0] step_term(input logic signed [STEP_W-1:0] s,
                                                         input logic [LEN_W-1:0] cs);
    logic signed [DIST_W-1:0] c;
    c = $signed({{(DIST_W-LEN_W){1'b0}}, cs});
    case (s)
      2'sb01:  return c;
      2'sb11:  return -c;
      2'sb10:  return -(c <<< 1);
      default: return '0;
    endcase
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      particle_count <= RST_PARTICLE_COUNT;
      particle_limit <= RST_PARTICLE_LIMIT;
      cell_len       <= RST_CELL_LEN;
      cutoff_squared <= RST_CUTOFF_SQUARED;
      cutoff_radius  <= RST_CUTOFF_RADIUS;
      energy_shift   <= '0;
      energy_slope   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PARTICLE_COUNT: particle_count <= cfg_data[COUNT_W-1:0];
        CFG_PARTICLE_LIMIT: particle_limit <= cfg_data[COUNT_W-1:0];
        CFG_CELL_LEN:       cell_len       <= cfg_data[LEN_W-1:0];
        CFG_CUTOFF_SQUARED: cutoff_squared <= cfg_data[LEN_W-1:0];
        CFG_CUTOFF_RADIUS:  cutoff_radius  <= cfg_data[LEN_W-1:0];
        CFG_ENERGY_SHIFT:   energy_shift   <= cfg_data;
        CFG_ENERGY_SLOPE:   energy_slope   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign ux       = dist_x[DIST_W-1] ? DIST_W'(0) - dist_x : dist_x;
  assign uy       = dist_y[DIST_W-1] ? DIST_W'(0) - dist_y : dist_y;
  assign far      = (ux[DIST_W-1:31] != '0) || (uy[DIST_W-1:31] != '0);
  assign used     = (oid != nid) && ({1'b0, nid} < particle_limit);
  assign cut_lim  = {33'd0, cutoff_squared} << F;
  assign inv2     = ((quo >> 63) != '0) ? S64_MAX : $signed({1'b0, quo[62:0]});
  assign diff     = $signed({2'b00, root}) - $signed({3'b000, cutoff_radius});
  assign diff_up  = 64'(diff) <<< UP_SH;
  assign eshift_up = 64'(energy_shift) <<< UP_SH;
  assign count1   = (particle_count == '0) ? COUNT_W'(1) : particle_count;
  assign mean64   = sum_e[63] ? 64'sd0 - $signed(64'(quo[63:8]))
                              : $signed(64'(quo[63:8]));

  always_comb begin
    op_a  = '0;
    op_b  = '0;
    op_sh = '0;
    unique case (cmd.op)
      OP_SQX:  begin op_a = 64'(ux); op_b = 64'(ux); end
      OP_SQY:  begin op_a = 64'(uy); op_b = 64'(uy); end
      OP_M1:   begin op_a = inv2; op_b = inv2; op_sh = SH_W'(WORK_FRAC); end
      OP_INV6: begin op_a = t1; op_b = inv2; op_sh = SH_W'(WORK_FRAC); end
      OP_M3:   begin op_a = inv2; op_b = inv6; op_sh = SH_W'(WORK_FRAC); end
      OP_F0:   begin op_a = t1; op_b = sat_sub(inv6, W_HALF); op_sh = SH_W'(WORK_FRAC); end
      OP_F:    begin op_a = t1; op_b = 64'sd48; end
      OP_AX:   begin op_a = frc; op_b = 64'(dist_x); op_sh = SH_W'(ACC_SH); end
      OP_AY:   begin op_a = frc; op_b = 64'(dist_y); op_sh = SH_W'(ACC_SH); end
      OP_PE0:  begin op_a = inv6; op_b = sat_sub(inv6, W_ONE); op_sh = SH_W'(WORK_FRAC); end
      OP_PE:   begin op_a = t1; op_b = 64'sd4; end
      OP_SL:   begin op_a = 64'(energy_slope); op_b = diff_up; op_sh = SH_W'(F); end
      default: ;
    endcase
  end

  always_comb begin
    if (cmd.div_mean) begin
      div_num = DIV_W'(mag(sum_e));
      div_den = 64'(count1);
    end else begin
      div_num = DIV_W'(1) << (WORK_FRAC + 2 * F);
      div_den = r2;
    end
  end

  ljpfa_mul u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.mul_start),
    .a      (op_a),
    .b      (op_b),
    .sh     (op_sh),
    .done   (mul_done),
    .result (mul_res)
  );

  ljpfa_div #(.W(DIV_W)) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (div_den),
    .busy  (div_busy),
    .quo   (quo)
  );

  ljpfa_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.sqrt_start),
    .val   (r2),
    .busy  (sqrt_busy),
    .root  (root)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      oid    <= own_id;
      nid    <= neighbour_id;
      ox     <= own_x;
      oy     <= own_y;
      nx     <= neighbour_x;
      ny     <= neighbour_y;
      sx     <= cell_step_x;
      sy     <= cell_step_y;
      last_n <= last_neighbour;
      last_s <= last_of_step;
    end
    if (cmd.calc_dist) begin
      dist_x <= DIST_W'(ox) - DIST_W'(nx) - step_term(sx, cell_len);
      dist_y <= DIST_W'(oy) - DIST_W'(ny) - step_term(sy, cell_len);
    end
    if (cmd.calc_r2) r2 <= sqx + sqy;
    if (mul_done) begin
      case (cmd.op) inside
        OP_SQX:  sqx <= mul_res;
        OP_SQY:  sqy <= mul_res;
        OP_INV6: inv6 <= mul_res;
        OP_F:    frc <= mul_res;
        OP_PE:   pe <= sat_sub(mul_res, eshift_up);
        OP_M1, OP_M3, OP_F0, OP_PE0: t1 <= mul_res;
        default: ;
      endcase
    end
    if (cmd.emit) begin
      accel_x     <= FIELD_W'(clamp(64'(sum_ax), FIELD_W));
      accel_y     <= FIELD_W'(clamp(64'(sum_ay), FIELD_W));
      mean_energy <= last_s ? FIELD_W'(clamp(mean64, FIELD_W)) : '0;
      step_done   <= last_s;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_ax <= '0;
      sum_ay <= '0;
      sum_e  <= '0;
    end else begin
      if (mul_done && cmd.op == OP_AX)
        sum_ax <= ACC_WIDTH'(clamp(sat_add(64'(sum_ax), mul_res), ACC_WIDTH));
      if (mul_done && cmd.op == OP_AY)
        sum_ay <= ACC_WIDTH'(clamp(sat_add(64'(sum_ay), mul_res), ACC_WIDTH));
      if (mul_done && cmd.op == OP_SL)
        sum_e <= sat_add(sum_e, sat_sub(pe, mul_res));
      if (cmd.emit) begin
        sum_ax <= '0;
        sum_ay <= '0;
        if (last_s) sum_e <= '0;
      end
    end
  end

  always_comb begin
    stat.skip      = !used || far;
    stat.r2_skip   = (r2 == 64'd0) || (r2 >= cut_lim);
    stat.mul_done  = mul_done;
    stat.div_busy  = div_busy;
    stat.sqrt_busy = sqrt_busy;
    stat.last_n    = last_n;
    stat.last_s    = last_s;
  end

endmodule

[design/ljpfa_ctrl.sv]
`timescale 1ns / 1ps
module ljpfa_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ljpfa_pkg::dp_cmd_t   cmd,
  input  ljpfa_pkg::dp_stat_t  stat
);
  import ljpfa_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DIST   = 4'd1;
  localparam logic [3:0] S_CHECK  = 4'd2;
  localparam logic [3:0] S_MSTART = 4'd3;
  localparam logic [3:0] S_MWAIT  = 4'd4;
  localparam logic [3:0] S_R2     = 4'd5;
  localparam logic [3:0] S_RCHK   = 4'd6;
  localparam logic [3:0] S_RWAIT  = 4'd7;
  localparam logic [3:0] S_FIN    = 4'd8;
  localparam logic [3:0] S_MEAN   = 4'd9;
  localparam logic [3:0] S_EMIT   = 4'd10;

  logic [3:0]      state;
  logic [3:0]      state_next;
  logic [OP_W-1:0] op;
  logic [OP_W-1:0] op_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    cmd.op     = op;
    state_next = state;
    op_next    = op;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DIST;
        end
      end
      S_DIST: begin
        cmd.calc_dist = 1'b1;
        state_next    = S_CHECK;
      end
      S_CHECK: begin
        if (stat.skip) state_next = S_FIN;
        else begin
          op_next    = OP_SQX;
          state_next = S_MSTART;
        end
      end
      S_MSTART: begin
        cmd.mul_start = 1'b1;
        state_next    = S_MWAIT;
      end
      S_MWAIT: begin
        if (stat.mul_done) begin
          if (op == OP_SQY) state_next = S_R2;
          else if (op == OP_SL) state_next = S_FIN;
          else begin
            op_next    = op + OP_W'(1);
            state_next = S_MSTART;
          end
        end
      end
      S_R2: begin
        cmd.calc_r2 = 1'b1;
        state_next  = S_RCHK;
      end
      S_RCHK: begin
        if (stat.r2_skip) state_next = S_FIN;
        else begin
          cmd.div_start  = 1'b1;
          cmd.sqrt_start = 1'b1;
          state_next     = S_RWAIT;
        end
      end
      S_RWAIT: begin
        if (!stat.div_busy && !stat.sqrt_busy) begin
          op_next    = OP_M1;
          state_next = S_MSTART;
        end
      end
      S_FIN: begin
        if (stat.last_s) begin
          cmd.div_start = 1'b1;
          cmd.div_mean  = 1'b1;
          state_next    = S_MEAN;
        end else if (stat.last_n) state_next = S_EMIT;
        else state_next = S_IDLE;
      end
      S_MEAN: begin
        cmd.div_mean = 1'b1;
        if (!stat.div_busy) state_next = S_EMIT;
      end
      S_EMIT: begin
        if (!out_valid || !out_stall) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      op        <= OP_SQX;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      op    <= op_next;
      if (cmd.emit) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

endmodule

[design/lj_pair_force_accumulator_top.sv]
`timescale 1ns / 1ps
// Channel   Direction  Handshake             Beat
// in        input      in_valid / in_stall   one candidate pair
// out       output     out_valid / out_stall one acceleration result, mean energy at step end
// cfg       input      cfg_we                one register write, cfg_index / cfg_data
//
// A pair is taken and then owns the datapath until it is done.
// A pair in range runs the 65-step reciprocal divider and twelve passes through
// the shared multiplier. A step end adds another divider pass for the mean energy.
// Reset clears all sums and loads the register defaults. The result sits in an
// output register, so out_stall holds only a later pair that must emit.
module lj_pair_force_accumulator_top #(
  parameter int COORD_FRAC_BITS = ljpfa_pkg::COORD_FRAC_BITS_DEF,
  parameter int ACC_WIDTH       = ljpfa_pkg::ACC_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [ljpfa_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [ljpfa_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [ljpfa_pkg::ID_W-1:0]            own_id,
  input  logic [ljpfa_pkg::ID_W-1:0]            neighbour_id,
  input  logic signed [ljpfa_pkg::POS_W-1:0]    own_x,
  input  logic signed [ljpfa_pkg::POS_W-1:0]    own_y,
  input  logic signed [ljpfa_pkg::POS_W-1:0]    neighbour_x,
  input  logic signed [ljpfa_pkg::POS_W-1:0]    neighbour_y,
  input  logic signed [ljpfa_pkg::STEP_W-1:0]   cell_step_x,
  input  logic signed [ljpfa_pkg::STEP_W-1:0]   cell_step_y,
  input  logic                                  last_neighbour,
  input  logic                                  last_of_step,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [ljpfa_pkg::FIELD_W-1:0]  accel_x,
  output logic signed [ljpfa_pkg::FIELD_W-1:0]  accel_y,
  output logic signed [ljpfa_pkg::FIELD_W-1:0]  mean_energy,
  output logic                                  step_done
);
  import ljpfa_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  ljpfa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .stat      (stat)
  );

  ljpfa_datapath #(
    .COORD_FRAC_BITS (COORD_FRAC_BITS),
    .ACC_WIDTH       (ACC_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .own_id         (own_id),
    .neighbour_id   (neighbour_id),
    .own_x          (own_x),
    .own_y          (own_y),
    .neighbour_x    (neighbour_x),
    .neighbour_y    (neighbour_y),
    .cell_step_x    (cell_step_x),
    .cell_step_y    (cell_step_y),
    .last_neighbour (last_neighbour),
    .last_of_step   (last_of_step),
    .cmd            (cmd),
    .stat           (stat),
    .accel_x        (accel_x),
    .accel_y        (accel_y),
    .mean_energy    (mean_energy),
    .step_done      (step_done)
  );

  a_one_pair: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("pair accepted while another is in flight");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || !out_stall))
    else $error("result overwrote a beat still held");

  a_div_free: assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |-> !stat.div_busy)
    else $error("divider restarted while busy");

endmodule

[tb/sv/lj_pair_force_accumulator_top_test.sv]
`timescale 1ns / 1ps
module lj_pair_force_accumulator_top_test;
  import ljpfa_pkg::*;

  localparam int LIMIT_CYCLES = 1500000;
  localparam int SETTLE       = 300;
  localparam longint MAXL = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint MINL = 64'sh8000_0000_0000_0000;

  typedef struct {
    logic [FIELD_W-1:0] ax;
    logic [FIELD_W-1:0] ay;
    logic [FIELD_W-1:0] me;
    logic               sd;
  } accel_beat_t;

  class force_scoreboard;
    logic [COUNT_W-1:0] count_reg, limit_reg;
    logic [LEN_W-1:0]   cell_reg, cut_sq_reg, cut_r_reg;
    longint             shift_reg, slope_reg;
    longint             acc_x, acc_y, acc_e;
    accel_beat_t        pending_q[$];
    int                 errors, beats, pairs_used, steps;

    function new();
      count_reg = RST_PARTICLE_COUNT;
      limit_reg = RST_PARTICLE_LIMIT;
      cell_reg = RST_CELL_LEN;
      cut_sq_reg = RST_CUTOFF_SQUARED;
      cut_r_reg = RST_CUTOFF_RADIUS;
      shift_reg = 0;
      slope_reg = 0;
      acc_x = 0;
      acc_y = 0;
      acc_e = 0;
      errors = 0;
      beats = 0;
      pairs_used = 0;
      steps = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
      case (idx)
        CFG_PARTICLE_COUNT: count_reg = v[COUNT_W-1:0];
        CFG_PARTICLE_LIMIT: limit_reg = v[COUNT_W-1:0];
        CFG_CELL_LEN:       cell_reg = v[LEN_W-1:0];
        CFG_CUTOFF_SQUARED: cut_sq_reg = v[LEN_W-1:0];
        CFG_CUTOFF_RADIUS:  cut_r_reg = v[LEN_W-1:0];
        CFG_ENERGY_SHIFT:   shift_reg = longint'($signed(v));
        CFG_ENERGY_SLOPE:   slope_reg = longint'($signed(v));
        default: ;
      endcase
    endfunction

    function longint add_sat(longint a, longint b);
      logic signed [64:0] s;
      s = $signed({a[63], a}) + $signed({b[63], b});
      if (s > $signed({1'b0, MAXL})) return MAXL;
      if (s < $signed({1'b1, MINL})) return MINL;
      return s[63:0];
    endfunction

    function longint sub_sat(longint a, longint b);
      logic signed [64:0] s;
      s = $signed({a[63], a}) - $signed({b[63], b});
      if (s > $signed({1'b0, MAXL})) return MAXL;
      if (s < $signed({1'b1, MINL})) return MINL;
      return s[63:0];
    endfunction

    function longint clip48(longint v);
      if (v > 64'sh0000_7FFF_FFFF_FFFF) return 64'sh0000_7FFF_FFFF_FFFF;
      if (v < -64'sh0000_8000_0000_0000) return -64'sh0000_8000_0000_0000;
      return v;
    endfunction

    function longint scale_mul(longint a, longint b, int sh);
      logic [63:0]  ua, ub;
      logic [127:0] p;
      bit           neg;
      neg = (a < 0) != (b < 0);
      ua = a[63] ? 64'd0 - a : a;
      ub = b[63] ? 64'd0 - b : b;
      p = {64'd0, ua} * {64'd0, ub};
      p = p >> sh;
      if (neg) begin
        if (p > 128'h8000_0000_0000_0000) return MINL;
        return 64'd0 - p[63:0];
      end
      if (p > 128'h7FFF_FFFF_FFFF_FFFF) return MAXL;
      return p[63:0];
    endfunction

    function logic [63:0] floor_root(logic [63:0] v);
      logic [63:0] res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
        if (v >= res + bitv) begin
          v = v - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return res;
    endfunction

    function void add_pair(longint ox, longint oy, longint nx, longint ny,
                           longint sx, longint sy);
      longint       dx, dy, inv2, inv6, frc, pe, diff;
      logic [63:0]  ux, uy, r2, root;
      logic [127:0] q;
      dx = ox - nx - sx * longint'(cell_reg);
      dy = oy - ny - sy * longint'(cell_reg);
      ux = dx[63] ? 64'd0 - dx : dx;
      uy = dy[63] ? 64'd0 - dy : dy;
      if (ux >= 64'h8000_0000 || uy >= 64'h8000_0000) return;
      r2 = ux * ux + uy * uy;
      if (r2 == 0 || r2 >= ({33'd0, cut_sq_reg} << COORD_FRAC_BITS_DEF)) return;
      pairs_used++;
      q = (128'd1 << (WORK_FRAC + 2 * COORD_FRAC_BITS_DEF)) / {64'd0, r2};
      inv2 = (q > 128'h7FFF_FFFF_FFFF_FFFF) ? MAXL : q[63:0];
      inv6 = scale_mul(scale_mul(inv2, inv2, WORK_FRAC), inv2, WORK_FRAC);
      frc = scale_mul(scale_mul(inv2, inv6, WORK_FRAC), sub_sat(inv6, W_HALF), WORK_FRAC);
      frc = scale_mul(frc, 48, 0);
      acc_x = clip48(add_sat(acc_x,
        scale_mul(frc, dx, WORK_FRAC + COORD_FRAC_BITS_DEF - OUT_FRAC)));
      acc_y = clip48(add_sat(acc_y,
        scale_mul(frc, dy, WORK_FRAC + COORD_FRAC_BITS_DEF - OUT_FRAC)));
      pe = scale_mul(scale_mul(inv6, sub_sat(inv6, W_ONE), WORK_FRAC), 4, 0);
      pe = sub_sat(pe, shift_reg * 65536);
      root = floor_root(r2);
      diff = longint'(root) - longint'(cut_r_reg);
      pe = sub_sat(pe, scale_mul(slope_reg, diff * 65536, COORD_FRAC_BITS_DEF));
      acc_e = add_sat(acc_e, pe);
    endfunction

    function void note_pair(logic [ID_W-1:0] oid, logic [ID_W-1:0] nid,
                            logic [POS_W-1:0] ox, logic [POS_W-1:0] oy,
                            logic [POS_W-1:0] nx, logic [POS_W-1:0] ny,
                            logic [STEP_W-1:0] sx, logic [STEP_W-1:0] sy,
                            logic ln, logic ls);
      accel_beat_t e;
      longint      cnt, mean;
      if (oid != nid && {1'b0, nid} < limit_reg)
        add_pair($signed(ox), $signed(oy), $signed(nx), $signed(ny),
                 $signed(sx), $signed(sy));
      if (!ln && !ls) return;
      e.ax = acc_x[FIELD_W-1:0];
      e.ay = acc_y[FIELD_W-1:0];
      acc_x = 0;
      acc_y = 0;
      e.me = 0;
      e.sd = 0;
      if (ls) begin
        cnt = (count_reg == 0) ? 1 : longint'(count_reg);
        mean = (acc_e / cnt) / 256;
        mean = clip48(mean);
        e.me = mean[FIELD_W-1:0];
        e.sd = 1;
        acc_e = 0;
      end
      pending_q.push_back(e);
    endfunction

    task report(string what, logic [FIELD_W-1:0] got, logic [FIELD_W-1:0] want);
      errors++;
      $display("mismatch at %0t: %s got %h want %h", $time, what, got, want);
    endtask

    task check_beat(logic [FIELD_W-1:0] ax, logic [FIELD_W-1:0] ay,
                    logic [FIELD_W-1:0] me, logic sd);
      accel_beat_t e;
      beats++;
      if (sd) steps++;
      if (pending_q.size() == 0) begin
        report("unexpected beat accel_x", ax, '0);
        return;
      end
      e = pending_q.pop_front();
      if (ax !== e.ax) report("accel_x", ax, e.ax);
      if (ay !== e.ay) report("accel_y", ay, e.ay);
      if (me !== e.me) report("mean_energy", me, e.me);
      if (sd !== e.sd) report("step_done", FIELD_W'(sd), FIELD_W'(e.sd));
    endtask

    function int pending();
      return pending_q.size();
    endfunction
  endclass

  logic clk, rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic in_valid, in_stall;
  logic [ID_W-1:0] own_id, neighbour_id;
  logic signed [POS_W-1:0] own_x, own_y, neighbour_x, neighbour_y;
  logic signed [STEP_W-1:0] cell_step_x, cell_step_y;
  logic last_neighbour, last_of_step;
  logic out_valid, out_stall;
  logic signed [FIELD_W-1:0] accel_x, accel_y, mean_energy;
  logic step_done;

  force_scoreboard sb;
  bit  idle_on;
  int  cycles = 0;
  int  id_span;
  logic [LEN_W-1:0] tb_cell;

  lj_pair_force_accumulator_top dut (.*);

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_beat(accel_x, accel_y, mean_energy, step_done);
    out_stall <= idle_on && ($urandom_range(99) < 23);
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, v);
    if (idx == CFG_CELL_LEN) tb_cell = v[LEN_W-1:0];
    @(posedge clk);
  endtask

  task automatic send_pair(logic [ID_W-1:0] oid, logic [ID_W-1:0] nid,
                           logic [POS_W-1:0] ox, logic [POS_W-1:0] oy,
                           logic [POS_W-1:0] nx, logic [POS_W-1:0] ny,
                           logic [STEP_W-1:0] sx, logic [STEP_W-1:0] sy,
                           logic ln, logic ls);
    while (idle_on && $urandom_range(99) < 23) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    own_id <= oid;
    neighbour_id <= nid;
    own_x <= ox;
    own_y <= oy;
    neighbour_x <= nx;
    neighbour_y <= ny;
    cell_step_x <= sx;
    cell_step_y <= sy;
    last_neighbour <= ln;
    last_of_step <= ls;
    do @(posedge clk); while (in_stall);
    sb.note_pair(oid, nid, ox, oy, nx, ny, sx, sy, ln, ls);
  endtask

  task automatic random_pair(bit ls);
    logic [ID_W-1:0]   oid, nid;
    logic [POS_W-1:0]  ox, oy, nx, ny;
    logic [STEP_W-1:0] sx, sy;
    longint            dx, dy;
    oid = ID_W'($urandom_range(0, id_span));
    case ($urandom_range(9))
      0: nid = oid;
      1: nid = ID_W'($urandom);
      default: nid = ID_W'($urandom_range(0, id_span));
    endcase
    sx = ($urandom_range(9) == 0) ? 2'b10 : 2'($signed($urandom_range(0, 2)) - 1);
    sy = ($urandom_range(9) == 0) ? 2'b10 : 2'($signed($urandom_range(0, 2)) - 1);
    if ($urandom_range(99) < 15) begin
      ox = $urandom;
      oy = $urandom;
      nx = $urandom;
      ny = $urandom;
    end else begin
      ox = $urandom_range(0, 163840);
      oy = $urandom_range(0, 163840);
      dx = longint'($urandom_range(0, 400000)) - 200000;
      dy = longint'($urandom_range(0, 400000)) - 200000;
      nx = POS_W'(longint'(ox) - dx - longint'($signed(sx)) * longint'(tb_cell));
      ny = POS_W'(longint'(oy) - dy - longint'($signed(sy)) * longint'(tb_cell));
    end
    send_pair(oid, nid, ox, oy, nx, ny, sx, sy, $urandom_range(5) == 0, ls);
  endtask

  task automatic random_run(int n);
    for (int i = 0; i < n; i++)
      random_pair(i == n - 1 || $urandom_range(29) == 0);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_all(logic [31:0] c, logic [31:0] l, logic [31:0] cs,
                           logic [31:0] cq, logic [31:0] cr,
                           logic [31:0] es, logic [31:0] el);
    write_reg(CFG_PARTICLE_COUNT, c);
    write_reg(CFG_PARTICLE_LIMIT, l);
    write_reg(CFG_CELL_LEN, cs);
    write_reg(CFG_CUTOFF_SQUARED, cq);
    write_reg(CFG_CUTOFF_RADIUS, cr);
    write_reg(CFG_ENERGY_SHIFT, es);
    write_reg(CFG_ENERGY_SLOPE, el);
  endtask

  initial begin
    sb = new();
    idle_on = 1'b1;
    id_span = 3000;
    tb_cell = RST_CELL_LEN;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    out_stall = 1'b0;
    own_id = '0;
    neighbour_id = '0;
    own_x = '0;
    own_y = '0;
    neighbour_x = '0;
    neighbour_y = '0;
    cell_step_x = '0;
    cell_step_y = '0;
    last_neighbour = 1'b0;
    last_of_step = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // defaults from reset
    send_pair(5, 5, 0, 0, 65536, 0, 0, 0, 1'b0, 1'b0);
    send_pair(0, 65535, 0, 0, 65536, 0, 0, 0, 1'b0, 1'b0);
    send_pair(1, 2, 1000, 1000, 1000, 1000, 0, 0, 1'b1, 1'b0);
    send_pair(1, 2, 32'h7FFF_FFFF, 0, 32'h8000_0000, 0, 0, 0, 1'b0, 1'b0);
    send_pair(1, 2, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              2'b01, 2'b11, 1'b1, 1'b0);
    send_pair(65535, 0, 65536, 65536, 0, 0, 0, 0, 1'b0, 1'b0);
    send_pair(3, 4, 100000, 50000, 20000, 160000, 2'b11, 2'b01, 1'b0, 1'b0);
    send_pair(3, 4, 10000, 10000, 150000, 150000, 2'b10, 2'b10, 1'b0, 1'b0);
    send_pair(3, 4, 150000, 150000, 10000, 10000, 2'b01, 2'b01, 1'b1, 1'b0);
    send_pair(3, 6, 80000, 80000, 20000, 20000, 2'b00, 2'b00, 1'b0, 1'b0);
    send_pair(3, 7, 1, 0, 0, 0, 2'b00, 2'b00, 1'b0, 1'b0);
    send_pair(3, 8, 0, 0, 160000, 0, 2'b00, 2'b00, 1'b0, 1'b1);
    send_pair(9, 10, 0, 0, 60000, 70000, 2'b00, 2'b00, 1'b1, 1'b1);
    random_run(90);
    drain();

    write_all(0, 1000, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    id_span = 1200;
    send_pair(7, 3, 0, 0, 0, 0, 2'b10, 2'b01, 1'b0, 1'b1);
    random_run(110);
    drain();

    write_all(65536, 65536, 32'h7FFF_FFFF, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF);
    id_span = 65535;
    idle_on = 1'b0;
    random_run(60);
    drain();

    write_all(100, 1, 163840, 409600, 163840, 12345, -5000);
    id_span = 2;
    random_run(100);
    idle_on = 1'b1;
    drain();

    write_all(7, 40000, 163840, 1000000, 250000, $urandom, $urandom);
    id_span = 45000;
    random_run(120);
    drain();

    write_reg(CFG_PARTICLE_COUNT, 0);
    random_run(50);
    drain();

    $display("checked %0d result beats (%0d step ends), %0d pairs inside cutoff",
             sb.beats, sb.steps, sb.pairs_used);
    $display("five register settings plus a zero count, extremes and cell step pattern 10");
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
